// File: rtl/core/stma_pkg.sv
// ----------------------------------------------------------------------------
// stma_pkg
// Shared widths and constants for the segment throughput moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package stma_pkg;

    localparam int MAX_WINDOW = 8;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int WIN_W      = 4;

    localparam int BYTES_W = 28;
    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int CASE_W  = 2;

    // bits-per-byte times microseconds-per-second
    localparam int SCALE_W = 23;
    localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(8000000);

    localparam int NUM_W  = BYTES_W + SCALE_W;        // rate numerator, 51 bits
    localparam int DEN_W  = TIME_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int SUM_W  = RATE_W + SLOT_W;          // sum of up to MAX_WINDOW rates
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(5);

    localparam logic [CASE_W-1:0] CASE_NONE    = 2'd0;
    localparam logic [CASE_W-1:0] CASE_PARTIAL = 2'd1;
    localparam logic [CASE_W-1:0] CASE_FULL    = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/segment_throughput_moving_average.sv
// ----------------------------------------------------------------------------
// segment_throughput_moving_average
// Segment rate from bytes and duration, pushed into a history ring; the
// estimate is the truncated mean of up to window_len most recent rates.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  in        sink       in_valid / in_ready    has_sample, segment_bytes,
//                                              start_time_us, end_time_us
//  out       source     out_valid / out_ready  estimate_bps, decision_case,
//                                              rate_saturated
//  cfg       sink       cfg_we                 cfg_data (window_len)
//
//  a request without a sample goes straight to ST_DONE; a sample runs ST_MUL
//  and ST_DIV_RATE (skipped when end is at or before start), ST_STORE, an
//  ST_SUM_RD/ST_SUM_ADD pair per rate averaged, then ST_DIV_MEAN. One shared restoring
//  divider retires one quotient bit per cycle, 51 steps for the rate and 43 for the mean.
//  in_ready is high only between items; the output register lets a new word
//  in while the previous result waits on out_ready.
//  rst_n clears control state and sets window_len to 5; the ring needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_throughput_moving_average
    import stma_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [WIN_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic                 has_sample,
    input  wire logic [BYTES_W-1:0]   segment_bytes,
    input  wire logic [TIME_W-1:0]    start_time_us,
    input  wire logic [TIME_W-1:0]    end_time_us,

    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [RATE_W-1:0]    estimate_bps,
    output      logic [CASE_W-1:0]    decision_case,
    output      logic                 rate_saturated
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_RATE,
        ST_STORE,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_DIV_MEAN,
        ST_DONE
    } state_t;

    state_t               state_reg,   state_next;
    logic [WIN_W-1:0]     win_reg,     win_next;
    logic [SLOT_W-1:0]    slot_reg,    slot_next;
    logic [CNT_W-1:0]     held_reg,    held_next;
    logic [BYTES_W-1:0]   bytes_reg,   bytes_next;
    logic [DEN_W-1:0]     den_reg,     den_next;
    logic [NUM_W-1:0]     num_reg,     num_next;
    logic [REM_W-1:0]     rem_reg,     rem_next;
    logic [STEP_W-1:0]    step_reg,    step_next;
    logic [RATE_W-1:0]    rate_reg,    rate_next;
    logic                 sat_reg,     sat_next;
    logic [CASE_W-1:0]    case_reg,    case_next;
    logic [CNT_W-1:0]     n_reg,       n_next;
    logic [CNT_W-1:0]     left_reg,    left_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [SUM_W-1:0]     sum_reg,     sum_next;
    logic [RATE_W-1:0]    est_reg,     est_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]    out_est_reg,   out_est_next;
    logic [CASE_W-1:0]    out_case_reg,  out_case_next;
    logic                 out_sat_reg,   out_sat_next;

    logic [RATE_W-1:0]    hist [MAX_WINDOW];
    logic [RATE_W-1:0]    rd_data_reg;
    logic                 hist_we;

    logic [TIME_W:0]      dur_diff;
    logic [NUM_W-1:0]     product;
    logic [REM_W-1:0]     rem_shift;
    logic                 q_bit;
    logic [REM_W-1:0]     rem_step;
    logic [NUM_W-1:0]     num_step;
    logic [CNT_W-1:0]     win_eff;
    logic [CNT_W-1:0]     held_inc;
    logic [SUM_W-1:0]     sum_add;

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign estimate_bps   = out_est_reg;
    assign decision_case  = out_case_reg;
    assign rate_saturated = out_sat_reg;

    // borrow or zero means end at or before start
    assign dur_diff = {1'b0, end_time_us} - {1'b0, start_time_us};
    assign product  = NUM_W'(bytes_reg) * NUM_W'(RATE_SCALE);

    // one restoring divide step
    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});
    assign rem_step  = q_bit ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    assign num_step  = {num_reg[NUM_W-2:0], q_bit};

    always_comb
    begin
        if (win_reg == '0)
            win_eff = CNT_W'(1);
        else if (CNT_W'(win_reg) > CNT_W'(MAX_WINDOW))
            win_eff = CNT_W'(MAX_WINDOW);
        else
            win_eff = CNT_W'(win_reg);
    end

    assign held_inc = (held_reg < CNT_W'(MAX_WINDOW)) ? (held_reg + 1'b1) : held_reg;
    assign sum_add  = sum_reg + SUM_W'(rd_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        win_next       = cfg_we ? cfg_data : win_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        bytes_next     = bytes_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        rate_next      = rate_reg;
        sat_next       = sat_reg;
        case_next      = case_reg;
        n_next         = n_reg;
        left_next      = left_reg;
        rd_slot_next   = rd_slot_reg;
        sum_next       = sum_reg;
        est_next       = est_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_est_next   = out_est_reg;
        out_case_next  = out_case_reg;
        out_sat_next   = out_sat_reg;
        hist_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bytes_next = segment_bytes;
                    den_next   = dur_diff[TIME_W-1:0];
                    if (!has_sample)
                    begin
                        est_next   = '0;
                        case_next  = CASE_NONE;
                        sat_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (dur_diff[TIME_W] || (dur_diff[TIME_W-1:0] == '0))
                    begin
                        rate_next  = RATE_MAX;
                        sat_next   = 1'b1;
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        sat_next   = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                num_next   = product;
                rem_next   = '0;
                step_next  = STEP_W'(NUM_W);
                state_next = ST_DIV_RATE;
            end

            ST_DIV_RATE:
            begin
                num_next  = num_step;
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    if (num_step[NUM_W-1:RATE_W] != '0)
                    begin
                        rate_next = RATE_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        rate_next = num_step[RATE_W-1:0];
                    end
                    state_next = ST_STORE;
                end
            end

            ST_STORE:
            begin
                hist_we      = 1'b1;
                slot_next    = (slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                     : slot_reg + 1'b1;
                held_next    = held_inc;
                if (held_inc < win_eff)
                begin
                    n_next    = held_inc;
                    left_next = held_inc;
                    case_next = CASE_PARTIAL;
                end
                else
                begin
                    n_next    = win_eff;
                    left_next = win_eff;
                    case_next = CASE_FULL;
                end
                rd_slot_next = slot_reg;
                sum_next     = '0;
                state_next   = ST_SUM_RD;
            end

            ST_SUM_RD:
            begin
                state_next = ST_SUM_ADD;
            end

            ST_SUM_ADD:
            begin
                sum_next     = sum_add;
                left_next    = left_reg - 1'b1;
                rd_slot_next = (rd_slot_reg == '0) ? SLOT_W'(MAX_WINDOW - 1)
                                                   : rd_slot_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    // sum sits in the top of the dividend, low bits shift out as zero
                    num_next   = {sum_add, {(NUM_W - SUM_W){1'b0}}};
                    rem_next   = '0;
                    den_next   = DEN_W'(n_reg);
                    step_next  = STEP_W'(SUM_W);
                    state_next = ST_DIV_MEAN;
                end
                else
                begin
                    state_next = ST_SUM_RD;
                end
            end

            ST_DIV_MEAN:
            begin
                num_next  = num_step;
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    est_next   = num_step[RATE_W-1:0];
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_est_next   = est_reg;
                    out_case_next  = case_reg;
                    out_sat_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_RESET;
            slot_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg    <= bytes_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        rate_reg     <= rate_next;
        sat_reg      <= sat_next;
        case_reg     <= case_next;
        n_reg        <= n_next;
        left_reg     <= left_next;
        rd_slot_reg  <= rd_slot_next;
        sum_reg      <= sum_next;
        est_reg      <= est_next;
        out_est_reg  <= out_est_next;
        out_case_reg <= out_case_next;
        out_sat_reg  <= out_sat_next;
    end

    // history ring
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist[slot_reg] <= rate_reg;
        rd_data_reg <= hist[rd_slot_reg];
    end

endmodule

`default_nettype wire
